// ===== hw/rtl/first_fit_heap_allocator_macros.svh =====
// assertion macros for the allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FFHA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [ST_W-1:0] ST_LARGE    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOROOM   = 3'd3;
  localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTCHUNK = 3'd5;
  localparam logic [ST_W-1:0] ST_FREED    = 3'd6;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [12:0] req_size;
    logic [12:0] free_offset;
  } ffha_in_t;

  typedef struct packed {
    logic [11:0] payload_offset;
    logic [2:0]  status;
  } ffha_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_SHR_RD, S_SHR_WR, S_FINISH,
    S_MRG_R_RD, S_MRG_R, S_MRG_L_RD, S_MRG_L, S_SHL_RD, S_SHL_WR, S_DONE
  } ffha_state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// allocate scans the chunks in order, then on a split shifts the later entries right by a read and a write each;
// free scans the chunks in order, then on each merge with a free neighbour shifts the later entries left
// one word at a time: busy stays high until the result strobe; results cannot be stalled
// the chunk table is one ram with separate read and write addresses, driven by the sequencer
// synchronous active-low reset: arena becomes one free chunk, no clearing pass needed
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned ARENA_BYTES = 4096,
  parameter int unsigned HDR_BYTES   = 32,
  parameter int unsigned MAX_CHUNKS  = 128
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire ffha_in_t  in_word,
  output logic           out_valid,
  output ffha_out_t      out_word
);
  localparam int unsigned AW = $clog2(MAX_CHUNKS);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned DW = 17;
  localparam int unsigned EW = 2 * DW + 1;
  localparam logic [DW-1:0] HDR = DW'(HDR_BYTES);
  localparam logic [DW-1:0] ARENA = DW'(ARENA_BYTES);

  typedef struct packed {
    logic          used;
    logic [DW-1:0] start;
    logic [DW-1:0] size;
  } ent_t;

  ffha_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic          mode_r;
  logic [DW-1:0] arg_r;
  ent_t          cur_r, cur_nxt, hold_r, hold_nxt;
  logic [11:0]   off_r, off_nxt;
  logic [2:0]    stat_r, stat_nxt;
  logic          init_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  ent_t          wdata, rd_raw, rd;
  logic [EW-1:0] wbits, rbits;

  assign wbits = wdata;
  assign rd_raw = ent_t'(rbits);
  ffha_ram #(.WIDTH(EW), .DEPTH(MAX_CHUNKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wbits), .raddr(raddr), .rdata(rbits)
  );
  // entry 0 until first written reads as reset value
  logic rd0_r;
  always_comb begin
    rd = rd_raw;
    if (init_r && rd0_r) rd = '{used: 1'b0, start: '0, size: ARENA - HDR};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= CW'(1); init_r <= 1'b1;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt;
      if (we && waddr == '0) init_r <= 1'b0;
    end
    rd0_r <= (raddr == '0);
    i_r <= i_nxt; j_r <= j_nxt; cur_r <= cur_nxt; hold_r <= hold_nxt;
    off_r <= off_nxt; stat_r <= stat_nxt;
    if (st_r == S_IDLE && start) begin
      mode_r <= in_word.mode;
      arg_r <= (in_word.mode == MODE_ALLOC) ? DW'(in_word.req_size) : DW'(in_word.free_offset);
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_word = '{payload_offset: off_r, status: stat_r};

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r;
    cur_nxt = cur_r; hold_nxt = hold_r; off_nxt = off_r; stat_nxt = stat_r;
    we = 1'b0; waddr = i_r[AW-1:0]; wdata = cur_r; raddr = i_r[AW-1:0];
    case (st_r)
      S_IDLE: begin
        off_nxt = '0; i_nxt = '0; raddr = '0;
        if (start) begin
          if (in_word.mode == MODE_ALLOC) begin
            if (in_word.req_size == '0) begin
              stat_nxt = ST_ZERO; st_nxt = S_DONE;
            end else if (DW'(in_word.req_size) + HDR > ARENA) begin
              stat_nxt = ST_LARGE; st_nxt = S_DONE;
            end else st_nxt = S_SCAN;
          end else if (DW'(in_word.free_offset) > ARENA) begin
            stat_nxt = ST_OUTSIDE; st_nxt = S_DONE;
          end else st_nxt = S_SCAN;
        end
      end
      S_SCAN_RD: st_nxt = S_SCAN;
      S_SCAN: begin
        cur_nxt = rd;
        raddr = AW'(i_r + CW'(1));
        if (mode_r == MODE_ALLOC) begin
          if (!rd.used && rd.size >= arg_r) begin
            off_nxt = 12'(rd.start + HDR);
            stat_nxt = ST_OK;
            cur_nxt.used = 1'b1;
            if (rd.size >= arg_r + HDR && cnt_r < CW'(MAX_CHUNKS)) begin
              cur_nxt.size = arg_r;
              hold_nxt = '{used: 1'b0, start: rd.start + HDR + arg_r,
                           size: rd.size - arg_r - HDR};
              j_nxt = i_r + CW'(1);
              st_nxt = S_SHR_RD;
            end else st_nxt = S_FINISH;
          end else if (i_r + CW'(1) >= cnt_r) begin
            stat_nxt = ST_NOROOM; st_nxt = S_DONE;
          end else begin
            i_nxt = i_r + CW'(1); st_nxt = S_SCAN;
          end
        end else begin
          if (rd.start + HDR == arg_r) begin
            if (!rd.used) begin
              stat_nxt = ST_FREED; st_nxt = S_DONE;
            end else begin
              stat_nxt = ST_OK; cur_nxt.used = 1'b0;
              st_nxt = S_MRG_R_RD;
            end
          end else if (i_r + CW'(1) >= cnt_r) begin
            stat_nxt = ST_NOTCHUNK; st_nxt = S_DONE;
          end else begin
            i_nxt = i_r + CW'(1); st_nxt = S_SCAN;
          end
        end
      end
      // insert hold at j, shifting following entries right
      S_SHR_RD: begin
        raddr = j_r[AW-1:0];
        st_nxt = S_SHR_WR;
      end
      S_SHR_WR: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = hold_r;
        hold_nxt = rd;
        if (j_r >= cnt_r) begin
          cnt_nxt = cnt_r + CW'(1); st_nxt = S_FINISH;
        end else begin
          j_nxt = j_r + CW'(1); st_nxt = S_SHR_RD;
        end
      end
      S_FINISH: begin
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = cur_r;
        st_nxt = S_DONE;
      end
      S_MRG_R_RD: begin
        raddr = AW'(i_r + CW'(1));
        st_nxt = S_MRG_R;
      end
      S_MRG_R: begin
        if (i_r + CW'(1) < cnt_r && !rd.used) begin
          cur_nxt.size = cur_r.size + rd.size + HDR;
          j_nxt = i_r + CW'(1); st_nxt = S_SHL_RD;
        end else st_nxt = S_MRG_L_RD;
      end
      S_MRG_L_RD: begin
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = cur_r;
        raddr = AW'(i_r - CW'(1));
        st_nxt = S_MRG_L;
      end
      S_MRG_L: begin
        if (i_r != '0 && !rd.used) begin
          cur_nxt = rd;
          cur_nxt.size = rd.size + cur_r.size + HDR;
          i_nxt = i_r - CW'(1);
          j_nxt = i_r;
          st_nxt = S_SHL_RD;
        end else st_nxt = S_DONE;
      end
      // remove entry j, shifting following entries left
      S_SHL_RD: begin
        raddr = AW'(j_r + CW'(1));
        if (j_r + CW'(1) >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt = hold_r.used ? S_FINISH : S_MRG_L_RD;
        end else st_nxt = S_SHL_WR;
      end
      S_SHL_WR: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = rd;
        j_nxt = j_r + CW'(1); st_nxt = S_SHL_RD;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    // hold.used marks that the left merge has been done
    if (st_r == S_MRG_R_RD) hold_nxt.used = 1'b0;
    if (st_r == S_MRG_L && i_r != '0 && !rd.used) hold_nxt.used = 1'b1;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ffha_checker.sv =====
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"
module ffha_checker import ffha_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire ffha_out_t out_word
);
  `FFHA_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `FFHA_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, busy)
  `FFHA_ASSERT_NXT(a_out_once, clk, rst_n, out_valid, !out_valid && !busy)
  `FFHA_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_word.status != ST_OK, out_word.payload_offset == '0)
  `FFHA_ASSERT_IMP(a_stat_rng, clk, rst_n, out_valid, out_word.status != 3'd7)
endmodule
bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);
`default_nettype wire
